@@ hdl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros, clocked on clk, muted during rst.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition must hold at every clock edge.
`define SODS_ASSERT(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Antecedent in this cycle implies consequent in the next.
`define SODS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ hdl/sods_pkg.sv @@
// ----------------------------------------------------------------------------
// sods_pkg
// Shared constants and types for the derivative stencil.
// ----------------------------------------------------------------------------
package sods_pkg;

  // Components per grid point (1 to 8).
  localparam int NVARS = 1;
  localparam int CW = (NVARS > 1) ? $clog2(NVARS) : 1;

  localparam int SAMPLE_W = 32;
  localparam int DER_W    = 35;
  localparam int SUM_W    = 36;
  localparam int PCNT_W   = 16;
  localparam logic [PCNT_W-1:0] PCNT_MAX = '1;

  localparam int IN_TDATA_W  = 32;
  localparam int OUT_TDATA_W = 40;

  localparam int QDEPTH = 4;
  localparam int QPW    = $clog2(QDEPTH);
  localparam int QCW    = $clog2(QDEPTH + 1);

  // Work for the back end: which stencil(s) to apply to one sample triple.
  typedef enum logic [1:0] {
    OP_INNER,        // central difference only
    OP_FIRST_INNER,  // one-sided first point, then central difference
    OP_END,          // one-sided last point
    OP_SHORT         // line too short: flagged zero
  } op_t;

  typedef struct packed {
    op_t                        op;
    logic                       last;
    logic signed [SAMPLE_W-1:0] s0;
    logic signed [SAMPLE_W-1:0] s1;
    logic signed [SAMPLE_W-1:0] s2;
  } entry_t;

endpackage

@@ hdl/sods_front.sv @@
// ----------------------------------------------------------------------------
// sods_front
// Accepts samples, keeps the per-component delay store, issues stencil work.
// ----------------------------------------------------------------------------
module sods_front (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [sods_pkg::IN_TDATA_W-1:0] s_tdata,  // [31:0] sample
  input  logic                          s_tlast,  // line_end
  input  logic                          q_full,
  output logic                          push,
  output sods_pkg::entry_t              push_entry
);
  import sods_pkg::*;

`include "assert_macros.svh"

  logic signed [SAMPLE_W-1:0] st0 [NVARS];
  logic signed [SAMPLE_W-1:0] st1 [NVARS];
  logic signed [SAMPLE_W-1:0] st2 [NVARS];

  logic [CW-1:0]     comp;
  logic [PCNT_W-1:0] pcnt;
  logic              sweeping;
  logic [CW-1:0]     sweep_idx;

  logic [CW-1:0]              rd_idx;
  logic signed [SAMPLE_W-1:0] rd0, rd1, rd2;
  logic signed [SAMPLE_W-1:0] sample;
  logic                       accept;
  logic                       started;   // point 2 reached
  logic                       sweep_push;
  logic                       sweep_done;
  logic                       comp_wrap;

  assign sample   = s_tdata[SAMPLE_W-1:0];
  assign s_tready = !sweeping && !q_full;
  assign accept   = s_tvalid && s_tready;
  assign started  = (pcnt >= PCNT_W'(2));

  // Single read port: the sweep owns it while input is held off.
  assign rd_idx = sweeping ? sweep_idx : comp;
  assign rd0    = st0[rd_idx];
  assign rd1    = st1[rd_idx];
  assign rd2    = st2[rd_idx];

  assign sweep_push = sweeping && !q_full;
  assign sweep_done = sweep_push && (sweep_idx == CW'(NVARS - 1));
  assign comp_wrap  = (comp == CW'(NVARS - 1));

  always_comb begin
    push            = 1'b0;
    push_entry.op   = OP_INNER;
    push_entry.last = 1'b0;
    push_entry.s0   = rd1;
    push_entry.s1   = rd2;
    push_entry.s2   = sample;
    if (sweeping) begin
      push            = sweep_push;
      push_entry.op   = OP_END;
      push_entry.last = (sweep_idx == CW'(NVARS - 1));
      push_entry.s0   = rd0;
      push_entry.s1   = rd1;
      push_entry.s2   = rd2;
    end else if (accept) begin
      if (!started) begin
        push            = s_tlast;
        push_entry.op   = OP_SHORT;
        push_entry.last = 1'b1;
      end else begin
        push          = 1'b1;
        push_entry.op = (pcnt == PCNT_W'(2)) ? OP_FIRST_INNER : OP_INNER;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      comp      <= '0;
      pcnt      <= '0;
      sweeping  <= 1'b0;
      sweep_idx <= '0;
      for (int i = 0; i < NVARS; i++) begin
        st0[i] <= '0;
        st1[i] <= '0;
        st2[i] <= '0;
      end
    end else begin
      if (accept) begin
        if (s_tlast && !started) begin
          // short line: nothing left to evaluate, drop the taps
          for (int i = 0; i < NVARS; i++) begin
            st0[i] <= '0;
            st1[i] <= '0;
            st2[i] <= '0;
          end
        end else begin
          st0[comp] <= rd1;
          st1[comp] <= rd2;
          st2[comp] <= sample;
        end
        if (s_tlast) begin
          comp <= '0;
          pcnt <= '0;
          if (started) begin
            sweeping  <= 1'b1;
            sweep_idx <= '0;
          end
        end else if (comp_wrap) begin
          comp <= '0;
          if (pcnt != PCNT_MAX) pcnt <= pcnt + PCNT_W'(1);
        end else begin
          comp <= comp + CW'(1);
        end
      end
      if (sweep_push) begin
        sweep_idx <= sweep_idx + CW'(1);
        if (sweep_done) begin
          sweeping <= 1'b0;
          for (int i = 0; i < NVARS; i++) begin
            st0[i] <= '0;
            st1[i] <= '0;
            st2[i] <= '0;
          end
        end
      end
    end
  end

  `SODS_ASSERT_NEXT(a_line_end_restarts, accept && s_tlast, comp == '0 && pcnt == '0,
    "counters not cleared after line end")
  `SODS_ASSERT(a_no_push_full, !(push && q_full), "push into full queue")

endmodule

@@ hdl/sods_queue.sv @@
// ----------------------------------------------------------------------------
// sods_queue
// Short FIFO of stencil work between front and back end.
// ----------------------------------------------------------------------------
module sods_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  sods_pkg::entry_t push_entry,
  output logic             full,
  input  logic             pop,
  output logic             head_valid,
  output sods_pkg::entry_t head
);
  import sods_pkg::*;

`include "assert_macros.svh"

  entry_t         mem [QDEPTH];
  logic [QPW-1:0] wr_ptr;
  logic [QPW-1:0] rd_ptr;
  logic [QCW-1:0] count;
  logic           do_pop;

  assign full       = (count == QCW'(QDEPTH));
  assign head_valid = (count != '0);
  assign head       = mem[rd_ptr];
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= push_entry;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push)   wr_ptr <= wr_ptr + QPW'(1);
      if (do_pop) rd_ptr <= rd_ptr + QPW'(1);
      if (push && !do_pop)      count <= count + QCW'(1);
      else if (!push && do_pop) count <= count - QCW'(1);
    end
  end

  `SODS_ASSERT(a_count_range, count <= QCW'(QDEPTH), "queue count out of range")
  `SODS_ASSERT(a_pop_nonempty, !pop || head_valid, "pop from empty queue")

endmodule

@@ hdl/sods_back.sv @@
// ----------------------------------------------------------------------------
// sods_back
// Evaluates the stencils and drives the registered result stream.
// ----------------------------------------------------------------------------
module sods_back (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            head_valid,
  input  sods_pkg::entry_t                head,
  output logic                            pop,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [sods_pkg::OUT_TDATA_W-1:0] m_tdata,  // [34:0] derivative
  output logic                            m_tlast,  // last
  output logic                            m_tuser   // error
);
  import sods_pkg::*;

`include "assert_macros.svh"

  logic                    phase;   // second result of a first-point entry
  logic                    load;
  logic signed [SUM_W-1:0] x0, x1, x2;
  logic signed [SUM_W-1:0] sum;
  logic [DER_W-1:0]        der;

  assign x0 = {{(SUM_W-SAMPLE_W){head.s0[SAMPLE_W-1]}}, head.s0};
  assign x1 = {{(SUM_W-SAMPLE_W){head.s1[SAMPLE_W-1]}}, head.s1};
  assign x2 = {{(SUM_W-SAMPLE_W){head.s2[SAMPLE_W-1]}}, head.s2};

  always_comb begin
    case (head.op)
      OP_FIRST_INNER: sum = phase ? (x2 - x0) : ((x1 <<< 2) - (x0 <<< 1) - x0 - x2);
      OP_INNER:       sum = x2 - x0;
      OP_END:         sum = x0 - (x1 <<< 2) + (x2 <<< 1) + x2;
      default:        sum = '0;
    endcase
  end

  // Halving by dropping the low bit rounds toward minus infinity.
  assign der  = sum[SUM_W-1:1];
  assign load = head_valid && (!m_tvalid || m_tready);
  assign pop  = load && !(head.op == OP_FIRST_INNER && !phase);

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
      phase    <= 1'b0;
    end else begin
      if (load) begin
        m_tvalid <= 1'b1;
        phase    <= !pop;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      m_tdata <= {{(OUT_TDATA_W-DER_W){1'b0}}, der};
      m_tlast <= head.last;
      m_tuser <= (head.op == OP_SHORT);
    end
  end

  `SODS_ASSERT(a_phase_op, !phase || (head_valid && head.op == OP_FIRST_INNER),
    "second phase without a first-point entry")

endmodule

@@ hdl/second_order_derivative_stencil.sv @@
// ----------------------------------------------------------------------------
// second_order_derivative_stencil
// Streaming undivided first derivative of one grid line, second order.
// ----------------------------------------------------------------------------
// Samples (signed Q16.16) arrive one word per cycle when tready allows, NVARS components
// interleaved per point, with tlast on the final word of the line. Each
// point's derivative leaves as a 35-bit signed Q19.16 word, never
// overflowing, halves rounded toward minus infinity: the first point uses
// (-3f0+4f1-f2)/2, interior points (f[i+1]-f[i-1])/2, the last point
// (f[n-3]-4f[n-2]+3f[n-1])/2. Component v of point i leaves once component
// v of point i+1 is in; the last point's words leave after the line end.
// A line of fewer than three points gives a single zero word with tlast and
// tuser (error) set. Input is taken at one word per clock while tready is high;
// the line-end word of a line of three or more points is followed by tready
// low while the front end reads the delay store out for the last-point
// stencils, one component per cycle while the work queue has room, over its
// single read port.
// The back end emits one result per cycle while the output accepts; the third
// point's words each cause two results, and the four-entry work queue between
// the two halves soaks up that burst. An input word's first result passes
// through the work queue and then the output register. tready on the output
// may stall at will: results sit in the output register while the queue keeps filling.
// ----------------------------------------------------------------------------
module second_order_derivative_stencil (
  input  logic                             clk,
  input  logic                             rst,
  // sample stream
  input  logic                             s_tvalid,
  output logic                             s_tready,
  input  logic [sods_pkg::IN_TDATA_W-1:0]  s_tdata,   // [31:0] sample
  input  logic                             s_tlast,   // line_end
  // derivative stream
  output logic                             m_tvalid,
  input  logic                             m_tready,
  output logic [sods_pkg::OUT_TDATA_W-1:0] m_tdata,   // [34:0] derivative, rest zero
  output logic                             m_tlast,   // last
  output logic                             m_tuser    // [0] error
);
  import sods_pkg::*;

  logic   q_full;
  logic   push;
  entry_t push_entry;
  logic   pop;
  logic   head_valid;
  entry_t head;

  // front end: delay store, point/component counting, work issue
  sods_front u_front (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tlast    (s_tlast),
    .q_full     (q_full),
    .push       (push),
    .push_entry (push_entry)
  );

  // work queue
  sods_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .full       (q_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head       (head)
  );

  // back end: stencil arithmetic and output register
  sods_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tlast    (m_tlast),
    .m_tuser    (m_tuser)
  );

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the streaming second-order derivative stencil.
// ----------------------------------------------------------------------------
// Grid lines go in as sample words. A scoreboard keeps its own copy of the
// per-component delay taps and counters, works out the derivative words each
// accepted sample gives, and checks every output word against them in order.
// The bench runs a directed part (short lines, extremes, rounding), then
// random lines under three idling settings. It holds the output off for a
// long stretch to back the block up.
// ----------------------------------------------------------------------------

typedef struct packed {
  logic [sods_pkg::DER_W-1:0] der;
  logic                       last;
  logic                       err;
} deriv_word_t;

class deriv_scoreboard;
  localparam int NV = sods_pkg::NVARS;

  logic signed [sods_pkg::SAMPLE_W-1:0] taps[NV][3];
  logic [sods_pkg::PCNT_W-1:0]          pts;
  int unsigned                          comp;
  deriv_word_t                          pending[$];
  int unsigned                          checked;
  int unsigned                          bad;

  function new();
    clear_line();
    checked = 0;
    bad     = 0;
  endfunction

  function void clear_line();
    for (int v = 0; v < NV; v++)
      for (int k = 0; k < 3; k++)
        taps[v][k] = '0;
    pts  = '0;
    comp = 0;
  endfunction

  // Halving is an arithmetic shift, so it rounds toward minus infinity.
  function logic [sods_pkg::DER_W-1:0] halve(longint sum);
    longint h;
    h = sum >>> 1;
    return h[sods_pkg::DER_W-1:0];
  endfunction

  function void expect_word(logic [sods_pkg::DER_W-1:0] der, logic lst, logic err);
    deriv_word_t w;
    w.der  = der;
    w.last = lst;
    w.err  = err;
    pending.push_back(w);
  endfunction

  function void note_sample(logic [sods_pkg::SAMPLE_W-1:0] smp, logic eol);
    int unsigned c;
    longint      f0, f1, f2;
    c = (comp >= NV) ? 0 : comp;
    taps[c][0] = taps[c][1];
    taps[c][1] = taps[c][2];
    taps[c][2] = smp;
    f0 = longint'(taps[c][0]);
    f1 = longint'(taps[c][1]);
    f2 = longint'(taps[c][2]);
    if (pts >= 2) begin
      // third point releases the one-sided first point ahead of its own
      if (pts == 2)
        expect_word(halve(4 * f1 - 3 * f0 - f2), 1'b0, 1'b0);
      expect_word(halve(f2 - f0), 1'b0, 1'b0);
    end
    if (eol) begin
      if (pts < 2) begin
        expect_word('0, 1'b1, 1'b1);
      end else begin
        for (int v = 0; v < NV; v++) begin
          f0 = longint'(taps[v][0]);
          f1 = longint'(taps[v][1]);
          f2 = longint'(taps[v][2]);
          expect_word(halve(f0 - 4 * f1 + 3 * f2), v == NV - 1, 1'b0);
        end
      end
      clear_line();
      return;
    end
    c++;
    if (c >= NV) begin
      c = 0;
      if (pts != sods_pkg::PCNT_MAX)
        pts++;
    end
    comp = c;
  endfunction

  function void note_bad(string msg);
    bad++;
    if (bad <= 10)
      $display("mismatch @%0t: %s", $time, msg);
  endfunction

  function void check_word(logic [sods_pkg::OUT_TDATA_W-1:0] data, logic tl, logic tu);
    deriv_word_t                     want;
    logic [sods_pkg::OUT_TDATA_W-1:0] want_data;
    if (pending.size() == 0) begin
      note_bad($sformatf("unexpected word tdata=%h tlast=%b tuser=%b", data, tl, tu));
      return;
    end
    want = pending.pop_front();
    want_data = '0;
    want_data[sods_pkg::DER_W-1:0] = want.der;
    checked++;
    if (data !== want_data || tl !== want.last || tu !== want.err)
      note_bad($sformatf("word %0d: tdata %h exp %h, tlast %b exp %b, tuser %b exp %b",
                         checked, data, want_data, tl, want.last, tu, want.err));
  endfunction

  function int unsigned outstanding();
    return pending.size();
  endfunction
endclass

module tb;
  import sods_pkg::*;

  localparam int WD_LIMIT   = 4000;   // cycles with no word moving on either side
  localparam int HOLD_LEN   = 300;    // long output hold-off
  localparam int DRAIN_GAP  = 12;     // settle time after the last expected word
  localparam int RAND_WORDS = 200;

  logic                   clk;
  logic                   rst;
  logic                   s_tvalid;
  logic                   s_tready;
  logic [IN_TDATA_W-1:0]  s_tdata;
  logic                   s_tlast;
  logic                   m_tvalid;
  logic                   m_tready;
  logic [OUT_TDATA_W-1:0] m_tdata;
  logic                   m_tlast;
  logic                   m_tuser;

  deriv_scoreboard book;

  int  src_idle_pct;   // chance in a hundred that the sender skips a cycle
  int  snk_idle_pct;   // same for the receiver
  bit  hold_req;
  int  hold_left;
  int  quiet_cycles;
  int  words_sent;
  int  lines_sent;
  int  short_lines;

  second_order_derivative_stencil dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Receiver: random back-pressure, or a counted hold-off on request.
  initial begin
    m_tready  <= 1'b0;
    hold_left  = 0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_left = HOLD_LEN;
        hold_req  = 1'b0;
      end
      if (hold_left > 0) begin
        m_tready <= 1'b0;
        hold_left--;
      end else begin
        m_tready <= ($urandom_range(99) >= snk_idle_pct);
      end
    end
  end

  // Outputs and handshakes are stable mid-cycle: check there, and run the
  // watchdog off the same samples.
  always @(negedge clk) begin
    if (!rst) begin
      if (m_tvalid && m_tready)
        book.check_word(m_tdata, m_tlast, m_tuser);
      if ((m_tvalid && m_tready) || (s_tvalid && s_tready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= WD_LIMIT) begin
        $display("timeout: no word moved for %0d cycles, %0d results still due",
                 WD_LIMIT, book.outstanding());
        $display("tb: FAIL");
        $finish;
      end
    end
  end

  // One sample word; returns at the edge that takes it.
  task automatic send_word(input logic [31:0] smp, input logic eol, input bit gaps);
    logic took;
    if (gaps)
      while ($urandom_range(99) < src_idle_pct) begin
        s_tvalid <= 1'b0;
        @(posedge clk);
      end
    s_tvalid <= 1'b1;
    s_tdata  <= smp;
    s_tlast  <= eol;
    took = 1'b0;
    while (!took) begin
      @(negedge clk);
      took = s_tready;
      @(posedge clk);
    end
    book.note_sample(smp, eol);
    words_sent++;
  endtask

  // tlast goes on the final word of the queue.
  task automatic send_line(input logic [31:0] words[$], input bit gaps);
    for (int i = 0; i < words.size(); i++)
      send_word(words[i], i == words.size() - 1, gaps);
    lines_sent++;
    if (words.size() < 2 * NVARS + 1)
      short_lines++;
  endtask

  // Directed line: each point's value repeated over all components.
  task automatic send_points(input logic [31:0] vals[$]);
    logic [31:0] words[$];
    foreach (vals[i])
      for (int v = 0; v < NVARS; v++)
        words.push_back(vals[i]);
    send_line(words, 1'b1);
  endtask

  task automatic send_random_line(input bit gaps);
    logic [31:0] words[$];
    int          npts;
    int          nw;
    int          kind;
    logic [31:0] base;
    logic [31:0] step;
    case ($urandom_range(9))
      0:       npts = 1;
      1:       npts = 2;
      2:       npts = 3;
      default: npts = $urandom_range(14, 4);
    endcase
    kind = $urandom_range(3);
    base = $urandom;
    step = $urandom_range(2 ** 20) - 2 ** 19;
    nw   = npts * NVARS;
    // early marker: cut the final point short
    if (NVARS > 1 && $urandom_range(3) == 0)
      nw -= $urandom_range(NVARS - 1);
    for (int i = 0; i < nw; i++)
      case (kind)
        0: words.push_back($urandom);
        1: case ($urandom_range(3))
             0:       words.push_back(32'h8000_0000);
             1:       words.push_back(32'h7FFF_FFFF);
             2:       words.push_back(32'h0000_0000);
             default: words.push_back(32'hFFFF_FFFF);
           endcase
        2:       words.push_back($urandom_range(2000) - 1000);
        default: words.push_back(base + (i / NVARS) * step + (i % NVARS));
      endcase
    send_line(words, gaps);
  endtask

  // Random lines until the word budget is spent.
  task automatic run_random(input int budget, input bit with_hold);
    int target;
    target = words_sent + budget;
    if (with_hold)
      hold_req = 1'b1;
    while (words_sent < target)
      send_random_line(1'b1);
  endtask

  // Sender stops until every expected word is back.
  task automatic drain();
    s_tvalid <= 1'b0;
    s_tlast  <= 1'b0;
    while (book.outstanding() != 0)
      @(posedge clk);
    repeat (DRAIN_GAP) @(posedge clk);
  endtask

  initial begin
    book         = new();
    hold_req     = 1'b0;
    quiet_cycles = 0;
    words_sent   = 0;
    lines_sent   = 0;
    short_lines  = 0;
    src_idle_pct = 34;
    snk_idle_pct = 58;
    rst      <= 1'b1;
    s_tvalid <= 1'b0;
    s_tdata  <= '0;
    s_tlast  <= 1'b0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: short lines, extremes of both stencils, rounding of odd sums
    send_points('{32'h7FFF_FFFF});
    send_points('{32'h8000_0000, 32'h7FFF_FFFF});
    send_points('{32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000});
    send_points('{32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF});
    send_points('{32'h0000_0001, 32'hFFFF_FFFF, 32'h0000_0002, 32'h8000_0000,
                  32'h7FFF_FFFF});
    send_points('{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF});
    drain();

    run_random(RAND_WORDS / 3, 1'b1);
    drain();

    src_idle_pct = 58;
    snk_idle_pct = 34;
    run_random(RAND_WORDS / 3, 1'b0);
    drain();

    // no idling: the hold-off here backs the block up at full input rate
    src_idle_pct = 0;
    snk_idle_pct = 0;
    run_random(RAND_WORDS / 3, 1'b1);
    drain();

    $display("summary: %0d sample words in %0d lines (%0d under three points),",
             words_sent, lines_sent, short_lines);
    $display("summary: %0d derivative words checked, %0d mismatches",
             book.checked, book.bad);
    if (book.bad == 0 && book.outstanding() == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule
